// File: design/ppm_p6_stream_parser_core_macros.svh
// Assertion macros used by the stream parser top level.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef PPM_P6_STREAM_PARSER_CORE_MACROS_SVH
`define PPM_P6_STREAM_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent holds in the same cycle as the antecedent.
`define PPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PPS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define PPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: design/pps_pkg.sv
// Shared types, codes and helpers for the P6 stream parser.
// No dependencies; every RTL file of the block imports it.
package pps_pkg;

   localparam int unsigned MAX_DIMENSION = 65535;
   localparam int unsigned ACC_W = 17;

   localparam logic [7:0] CHR_P    = 8'h50;
   localparam logic [7:0] CHR_SIX  = 8'h36;
   localparam logic [7:0] CHR_HASH = 8'h23;
   localparam logic [7:0] CHR_LF   = 8'h0A;
   localparam logic [7:0] CHR_PLUS = 8'h2B;
   localparam logic [7:0] CHR_MIN  = 8'h2D;
   localparam logic [7:0] CHR_ZERO = 8'h30;
   localparam logic [7:0] CHR_NINE = 8'h39;
   localparam logic [7:0] CHR_SP   = 8'h20;
   localparam logic [7:0] CHR_TAB  = 8'h09;
   localparam logic [7:0] CHR_CR   = 8'h0D;

   typedef enum logic [3:0] {
      PH_MAGIC_P = 4'd0,
      PH_MAGIC_6 = 4'd1,
      PH_PRE_W   = 4'd2,
      PH_NUM_W   = 4'd3,
      PH_PRE_H   = 4'd4,
      PH_NUM_H   = 4'd5,
      PH_PRE_M   = 4'd6,
      PH_NUM_M   = 4'd7,
      PH_EOL     = 4'd8,
      PH_PIXELS  = 4'd9,
      PH_DONE    = 4'd10,
      PH_FAILED  = 4'd11
   } pps_phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } pps_kind_type;

   typedef enum logic [1:0] {
      ERR_NOT_P6     = 2'd0,
      ERR_BAD_NUMBER = 2'd1,
      ERR_SHORT_DATA = 2'd2
   } pps_err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } pps_req_type;

   typedef struct packed {
      pps_kind_type result_kind;
      logic [15:0]  image_width;
      logic [15:0]  image_height;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic [15:0]  pixel_column;
      logic [15:0]  pixel_row;
      logic         last_pixel;
      pps_err_type  error_code;
   } pps_rsp_type;

   // Outcome of one byte seen while skipping ahead of a number.
   typedef struct packed {
      logic             bad;
      logic             comment;
      logic             advance;
      logic             negative;
      logic             started;
      logic [ACC_W-1:0] acc;
   } pps_pre_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHR_ZERO) && (c <= CHR_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHR_SP) || ((c >= CHR_TAB) && (c <= CHR_CR));
   endfunction

   function automatic pps_pre_type pre_byte(input logic [7:0] c, input logic in_cmt);
      pps_pre_type r;
      r = '0;
      r.comment = in_cmt;
      if (in_cmt) begin
         if (c == CHR_LF) r.comment = 1'b0;
      end else if (is_space(c)) begin
         r.bad = 1'b0;
      end else if (c == CHR_HASH) begin
         r.comment = 1'b1;
      end else if ((c == CHR_PLUS) || (c == CHR_MIN)) begin
         r.advance  = 1'b1;
         r.negative = (c == CHR_MIN);
      end else if (is_digit(c)) begin
         r.advance = 1'b1;
         r.started = 1'b1;
         r.acc     = ACC_W'(c - CHR_ZERO);
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

endpackage

// File: design/pps_parser.sv
// Byte-level header and pixel parser: phase register plus one-step update.
// Depends on pps_pkg; produces at most one result word per accepted byte.
module pps_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  pps_pkg::pps_req_type  req,
   output logic                  res_valid,
   output pps_pkg::pps_rsp_type  res,
   output pps_pkg::pps_phase_type phase
);
   import pps_pkg::*;

   pps_phase_type    phase_ff, phase_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic             started_ff, started_in;
   logic             comment_ff, comment_in;
   logic [15:0]      width_ff, width_in;
   logic [15:0]      height_ff, height_in;
   logic [1:0]       chan_ff, chan_in;
   logic [15:0]      rg_ff, rg_in;
   logic [15:0]      col_ff, col_in;
   logic [15:0]      row_ff, row_in;

   logic             ev_err, ev_hdr, ev_pix, ev_last;
   pps_err_type      ev_code;

   logic [7:0]       c;
   logic [19:0]      acc_x10;
   logic [ACC_W-1:0] acc_sat;
   pps_pre_type      pre_cur, pre_new;
   logic             col_wrap, row_wrap;

   assign c       = req.data_byte;
   assign acc_x10 = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + 20'(c - CHR_ZERO);
   assign acc_sat = (acc_x10 > 20'(MAX_DIMENSION + 1)) ? ACC_W'(MAX_DIMENSION + 1)
                                                      : acc_x10[ACC_W-1:0];
   assign pre_cur  = pre_byte(c, comment_ff);
   assign pre_new  = pre_byte(c, 1'b0);
   assign col_wrap = ({1'b0, col_ff} + 17'd1) >= {1'b0, width_ff};
   assign row_wrap = ({1'b0, row_ff} + 17'd1) >= {1'b0, height_ff};
   assign phase    = phase_ff;

   // Next state and event decode.
   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      comment_in = comment_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      chan_in    = chan_ff;
      rg_in      = rg_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      ev_err     = 1'b0;
      ev_hdr     = 1'b0;
      ev_pix     = 1'b0;
      ev_last    = 1'b0;
      ev_code    = ERR_NOT_P6;

      if (req.end_of_stream) begin
         case (phase_ff)
            PH_MAGIC_P, PH_MAGIC_6: begin
               ev_err  = 1'b1;
               ev_code = ERR_NOT_P6;
            end
            PH_PRE_W, PH_NUM_W, PH_PRE_H, PH_NUM_H, PH_PRE_M: begin
               ev_err  = 1'b1;
               ev_code = ERR_BAD_NUMBER;
            end
            PH_NUM_M: begin
               ev_err  = 1'b1;
               ev_code = started_ff ? ERR_SHORT_DATA : ERR_BAD_NUMBER;
            end
            PH_EOL, PH_PIXELS: begin
               ev_err  = 1'b1;
               ev_code = ERR_SHORT_DATA;
            end
            default: ev_err = 1'b0;
         endcase
         // re-arm: back to the reset state
         phase_in   = PH_MAGIC_P;
         acc_in     = '0;
         neg_in     = 1'b0;
         started_in = 1'b0;
         comment_in = 1'b0;
         width_in   = '0;
         height_in  = '0;
         chan_in    = '0;
         rg_in      = '0;
         col_in     = '0;
         row_in     = '0;
      end else begin
         case (phase_ff)
            PH_MAGIC_P: begin
               if (c != CHR_P) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_NOT_P6;
               end else begin
                  phase_in = PH_MAGIC_6;
               end
            end
            PH_MAGIC_6: begin
               if (c != CHR_SIX) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_NOT_P6;
               end else begin
                  phase_in   = PH_PRE_W;
                  comment_in = 1'b0;
               end
            end
            PH_PRE_W, PH_PRE_H, PH_PRE_M: begin
               if (pre_cur.bad) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_BAD_NUMBER;
               end else begin
                  comment_in = pre_cur.comment;
                  if (pre_cur.advance) begin
                     neg_in     = pre_cur.negative;
                     started_in = pre_cur.started;
                     acc_in     = pre_cur.acc;
                     phase_in   = pps_phase_type'(4'(phase_ff) + 4'd1);
                  end
               end
            end
            PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
               if (is_digit(c)) begin
                  acc_in     = acc_sat;
                  started_in = 1'b1;
               end else if (!started_ff) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_BAD_NUMBER;
               end else if (phase_ff == PH_NUM_M) begin
                  phase_in = PH_EOL;
                  if (c == CHR_LF) ev_hdr = 1'b1;
               end else if (neg_ff || (acc_ff == '0) ||
                            (acc_ff > ACC_W'(MAX_DIMENSION))) begin
                  ev_err  = 1'b1;
                  ev_code = ERR_BAD_NUMBER;
               end else begin
                  if (phase_ff == PH_NUM_W) width_in = acc_ff[15:0];
                  else                      height_in = acc_ff[15:0];
                  // this byte also opens the skip ahead of the next number
                  if (pre_new.bad) begin
                     ev_err  = 1'b1;
                     ev_code = ERR_BAD_NUMBER;
                  end else begin
                     comment_in = pre_new.comment;
                     phase_in   = pps_phase_type'(4'(phase_ff) + 4'd1);
                     if (pre_new.advance) begin
                        neg_in     = pre_new.negative;
                        started_in = pre_new.started;
                        acc_in     = pre_new.acc;
                        phase_in   = pps_phase_type'(4'(phase_ff) + 4'd2);
                     end
                  end
               end
            end
            PH_EOL: begin
               if (c == CHR_LF) ev_hdr = 1'b1;
            end
            PH_PIXELS: begin
               case (chan_ff)
                  2'd0: begin
                     rg_in   = {c, 8'h00};
                     chan_in = 2'd1;
                  end
                  2'd1: begin
                     rg_in   = {rg_ff[15:8], c};
                     chan_in = 2'd2;
                  end
                  default: begin
                     ev_pix  = 1'b1;
                     chan_in = 2'd0;
                     if (col_wrap) begin
                        col_in = '0;
                        if (row_wrap) begin
                           ev_last  = 1'b1;
                           phase_in = PH_DONE;
                        end else begin
                           row_in = row_ff + 16'd1;
                        end
                     end else begin
                        col_in = col_ff + 16'd1;
                     end
                  end
               endcase
            end
            default: ev_err = 1'b0;
         endcase

         if (ev_err) phase_in = PH_FAILED;
         if (ev_hdr) begin
            phase_in = PH_PIXELS;
            chan_in  = '0;
            rg_in    = '0;
            col_in   = '0;
            row_in   = '0;
         end
      end
   end

   // Result word.
   always_comb begin
      res       = '0;
      res_valid = step && (ev_err || ev_hdr || ev_pix);
      if (ev_err) begin
         res.result_kind = KIND_ERROR;
         res.error_code  = ev_code;
      end else if (ev_hdr) begin
         res.result_kind  = KIND_HEADER;
         res.image_width  = width_ff;
         res.image_height = height_ff;
      end else if (ev_pix) begin
         res.result_kind  = KIND_PIXEL;
         res.red          = rg_ff[15:8];
         res.green        = rg_ff[7:0];
         res.blue         = c;
         res.pixel_column = col_ff;
         res.pixel_row    = row_ff;
         res.last_pixel   = ev_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC_P;
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
         started_ff <= 1'b0;
         comment_ff <= 1'b0;
         width_ff   <= '0;
         height_ff  <= '0;
         chan_ff    <= '0;
         rg_ff      <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         started_ff <= started_in;
         comment_ff <= comment_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         chan_ff    <= chan_in;
         rg_ff      <= rg_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

endmodule

// File: design/pps_out_buf.sv
// Result register with a skid stage so the parser keeps taking bytes
// while the consumer stalls, until the skid stage also holds a word. Depends on pps_pkg.
module pps_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pps_pkg::pps_rsp_type push_word,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pps_pkg::pps_rsp_type rsp_data
);
   import pps_pkg::*;

   logic        main_valid_ff, main_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   pps_rsp_type main_ff, main_in;
   pps_rsp_type skid_ff, skid_in;
   logic        pop;

   assign pop       = main_valid_ff && !rsp_stall;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;
   assign full      = skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no push possible here: the input side is stalled
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// File: design/ppm_p6_stream_parser_core.sv
// Channel  | Direction | Ports                         | Word
// req      | in        | req_valid req_stall req_data  | data_byte, end_of_stream
// rsp      | out       | rsp_valid rsp_stall rsp_data  | header / pixel / error result
//
// One byte per clock unless req_stall is high; a result is registered in the result
// register or, while that register stalls, the skid stage; one state step per byte.
// req_stall rises only when both result register and skid stage hold words.
// Reset is synchronous; afterwards the parser expects the 'P' of a new file.
// Top level of the P6 stream parser; depends on pps_pkg, pps_parser, pps_out_buf
// and the assertion macros header.
`include "ppm_p6_stream_parser_core_macros.svh"

module ppm_p6_stream_parser_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pps_pkg::pps_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pps_pkg::pps_rsp_type rsp_data
);
   import pps_pkg::*;

   logic          step;
   logic          res_valid;
   pps_rsp_type   res;
   pps_phase_type parse_phase;

   assign step = req_valid && !req_stall;

   pps_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_data),
      .res_valid (res_valid),
      .res       (res),
      .phase     (parse_phase)
   );

   pps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `PPS_ASSERT_SAME(a_stall_needs_result, clock, reset, req_stall, rsp_valid)
   `PPS_ASSERT_SAME(a_last_is_pixel, clock, reset, rsp_valid && rsp_data.last_pixel, rsp_data.result_kind == KIND_PIXEL)
   `PPS_ASSERT_NEXT(a_eos_rearms, clock, reset, step && req_data.end_of_stream, parse_phase == PH_MAGIC_P)

endmodule

// File: dv/tb.sv
// Self-checking testbench for the P6 stream parser core: directed and random PPM files.
// Depends on pps_pkg and the ppm_p6_stream_parser_core RTL; predicts each result in place.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pps_pkg::*;

   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned HOLD_CYCLES = 64;
   localparam int unsigned RANDOM_WORDS = 470;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pps_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pps_rsp_type rsp_data;

   ppm_p6_stream_parser_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Parser state as the testbench expects it
   pps_phase_type    parse_at;
   logic [ACC_W-1:0] num_acc;
   logic             num_neg;
   logic             num_seen;
   logic             in_note;
   logic [15:0]      img_w;
   logic [15:0]      img_h;
   logic [1:0]       chan;
   logic [15:0]      held_rg;
   logic [15:0]      col;
   logic [15:0]      row;

   pps_rsp_type result_q[$];
   int unsigned mismatches = 0;
   int unsigned words_sent = 0;
   int unsigned quiet = 0;

   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   bit          hold_ask = 1'b0;
   bit          hold_seen = 1'b0;
   int unsigned hold_left = 0;

   logic [7:0] file_q[$];

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHR_SP) || ((c >= CHR_TAB) && (c <= CHR_CR));
   endfunction

   function automatic logic is_decimal(input logic [7:0] c);
      return (c >= CHR_ZERO) && (c <= CHR_NINE);
   endfunction

   task automatic clear_parser();
      parse_at = PH_MAGIC_P;
      num_acc  = '0;
      num_neg  = 1'b0;
      num_seen = 1'b0;
      in_note  = 1'b0;
      img_w    = '0;
      img_h    = '0;
      chan     = '0;
      held_rg  = '0;
      col      = '0;
      row      = '0;
   endtask

   // Handle one byte of the skip ahead of a number; return 1 when it is illegal.
   function automatic logic skip_byte(input logic [7:0] c);
      if (in_note) begin
         if (c == CHR_LF) in_note = 1'b0;
         return 1'b0;
      end
      if (is_blank(c)) return 1'b0;
      if (c == CHR_HASH) begin
         in_note = 1'b1;
         return 1'b0;
      end
      if ((c == CHR_PLUS) || (c == CHR_MIN)) begin
         num_neg  = (c == CHR_MIN);
         num_seen = 1'b0;
         num_acc  = '0;
         parse_at = pps_phase_type'(parse_at + 4'd1);
         return 1'b0;
      end
      if (is_decimal(c)) begin
         num_neg  = 1'b0;
         num_seen = 1'b1;
         num_acc  = ACC_W'(c - CHR_ZERO);
         parse_at = pps_phase_type'(parse_at + 4'd1);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic parse_word(input pps_req_type w);
      pps_rsp_type r;
      logic [7:0]  c;
      logic        give;
      logic        err_hit;
      pps_err_type err;
      int unsigned v;
      r = '0;
      give = 1'b0;
      err_hit = 1'b0;
      err = ERR_NOT_P6;
      c = w.data_byte;
      if (w.end_of_stream) begin
         case (parse_at)
            PH_MAGIC_P, PH_MAGIC_6: begin
               err_hit = 1'b1;
               err = ERR_NOT_P6;
            end
            PH_PRE_W, PH_NUM_W, PH_PRE_H, PH_NUM_H, PH_PRE_M, PH_NUM_M: begin
               err_hit = 1'b1;
               err = (parse_at == PH_NUM_M && num_seen) ? ERR_SHORT_DATA : ERR_BAD_NUMBER;
            end
            PH_EOL, PH_PIXELS: begin
               err_hit = 1'b1;
               err = ERR_SHORT_DATA;
            end
            default: ;
         endcase
      end else begin
         case (parse_at)
            PH_MAGIC_P: begin
               if (c != CHR_P) begin
                  err_hit = 1'b1;
                  err = ERR_NOT_P6;
               end else parse_at = PH_MAGIC_6;
            end
            PH_MAGIC_6: begin
               if (c != CHR_SIX) begin
                  err_hit = 1'b1;
                  err = ERR_NOT_P6;
               end else begin
                  parse_at = PH_PRE_W;
                  in_note = 1'b0;
               end
            end
            PH_PRE_W, PH_PRE_H, PH_PRE_M: begin
               if (skip_byte(c)) begin
                  err_hit = 1'b1;
                  err = ERR_BAD_NUMBER;
               end
            end
            PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
               if (is_decimal(c)) begin
                  v = num_acc * 10 + (c - CHR_ZERO);
                  if (v > MAX_DIMENSION + 1) v = MAX_DIMENSION + 1;
                  num_acc = ACC_W'(v);
                  num_seen = 1'b1;
               end else if (!num_seen) begin
                  err_hit = 1'b1;
                  err = ERR_BAD_NUMBER;
               end else if (parse_at == PH_NUM_M) begin
                  parse_at = PH_EOL;
                  if (c == CHR_LF) give = 1'b1;
               end else if (num_neg || num_acc == 0 || num_acc > MAX_DIMENSION) begin
                  err_hit = 1'b1;
                  err = ERR_BAD_NUMBER;
               end else begin
                  if (parse_at == PH_NUM_W) img_w = num_acc[15:0];
                  else img_h = num_acc[15:0];
                  parse_at = pps_phase_type'(parse_at + 4'd1);
                  in_note = 1'b0;
                  if (skip_byte(c)) begin
                     err_hit = 1'b1;
                     err = ERR_BAD_NUMBER;
                  end
               end
            end
            PH_EOL: begin
               if (c == CHR_LF) give = 1'b1;
            end
            PH_PIXELS: begin
               if (chan == 2'd0) begin
                  held_rg = {c, 8'h00};
                  chan = 2'd1;
               end else if (chan == 2'd1) begin
                  held_rg[7:0] = c;
                  chan = 2'd2;
               end else begin
                  r.result_kind  = KIND_PIXEL;
                  r.red          = held_rg[15:8];
                  r.green        = held_rg[7:0];
                  r.blue         = c;
                  r.pixel_column = col;
                  r.pixel_row    = row;
                  chan = 2'd0;
                  if (32'(col) + 1 >= 32'(img_w)) begin
                     col = '0;
                     if (32'(row) + 1 >= 32'(img_h)) begin
                        r.last_pixel = 1'b1;
                        parse_at = PH_DONE;
                     end else row = row + 16'd1;
                  end else col = col + 16'd1;
                  result_q.push_back(r);
               end
            end
            default: ;
         endcase
         // a newline ending the header line gives the header word
         if (give) begin
            r = '0;
            r.result_kind  = KIND_HEADER;
            r.image_width  = img_w;
            r.image_height = img_h;
            parse_at = PH_PIXELS;
            chan     = '0;
            held_rg  = '0;
            col      = '0;
            row      = '0;
            result_q.push_back(r);
         end
      end
      if (err_hit) begin
         r = '0;
         r.result_kind = KIND_ERROR;
         r.error_code  = err;
         parse_at = PH_FAILED;
         result_q.push_back(r);
      end
      if (w.end_of_stream) clear_parser();
   endtask

   task automatic compare_field(input string tag, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result(input pps_rsp_type want, input pps_rsp_type got);
      compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
      compare_field("image_width", want.image_width, got.image_width);
      compare_field("image_height", want.image_height, got.image_height);
      compare_field("red", 16'(want.red), 16'(got.red));
      compare_field("green", 16'(want.green), 16'(got.green));
      compare_field("blue", 16'(want.blue), 16'(got.blue));
      compare_field("pixel_column", want.pixel_column, got.pixel_column);
      compare_field("pixel_row", want.pixel_row, got.pixel_row);
      compare_field("last_pixel", 16'(want.last_pixel), 16'(got.last_pixel));
      compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
   endtask

   // Predict on every accepted input word, check every accepted result word
   always @(posedge clock) begin
      pps_rsp_type want;
      logic        moved;
      moved = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         parse_word(req_data);
         moved = 1'b1;
      end
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         moved = 1'b1;
         if (result_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = result_q.pop_front();
            check_result(want, rsp_data);
         end
      end
      if (moved) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, a counted hold-off when one is requested, or no stalls
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rx_idle_on) begin
         rsp_stall <= ($urandom_range(99) < 29);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(input pps_req_type w);
      if (tx_idle_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 29);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      pps_req_type w;
      w.data_byte = b;
      w.end_of_stream = 1'b0;
      send_word(w);
   endtask

   task automatic send_end();
      pps_req_type w;
      w.data_byte = 8'($urandom_range(255));
      w.end_of_stream = 1'b1;
      send_word(w);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Drop valid and hold until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (result_q.size() != 0);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(5))
         0: return CHR_SP;
         1: return CHR_TAB;
         2: return CHR_LF;
         3: return 8'h0B;
         4: return 8'h0C;
         default: return CHR_CR;
      endcase
   endfunction

   task automatic add_gap(input int unsigned min_n);
      int unsigned k;
      logic [7:0]  b;
      repeat ($urandom_range(3, min_n)) begin
         k = $urandom_range(99);
         if (k < 15) begin
            file_q.push_back(CHR_HASH);
            repeat ($urandom_range(4)) begin
               b = 8'($urandom_range(255));
               if (b == CHR_LF) b = CHR_HASH;
               file_q.push_back(b);
            end
            file_q.push_back(CHR_LF);
         end else if (k < 17) begin
            file_q.push_back("x");
         end else begin
            file_q.push_back(pick_blank());
         end
      end
   endtask

   task automatic add_number(input bit dim, output bit ok, output int unsigned val);
      int unsigned k;
      bit          neg;
      bit          signed_txt;
      bit          digits;
      k = $urandom_range(99);
      if (!dim) val = $urandom_range(65535);
      else if (k < 86) val = $urandom_range(4, 1);
      else if (k < 89) val = 0;
      else if (k < 93) val = MAX_DIMENSION;
      else if (k < 96) val = MAX_DIMENSION + 1;
      else val = $urandom_range(9999999, 100000);
      k = $urandom_range(99);
      neg = (k >= 6 && k < 9);
      signed_txt = (k < 9);
      if (signed_txt) add_text(neg ? "-" : "+");
      digits = !(signed_txt && $urandom_range(99) < 20);
      if (digits) begin
         if ($urandom_range(99) < 8) add_text("0");
         add_text($sformatf("%0d", val));
      end
      ok = digits && (!dim || (!neg && val >= 1 && val <= MAX_DIMENSION));
   endtask

   // Build one file, mostly well formed, with random breaks and early ends
   task automatic send_random_file();
      bit          ok_w, ok_h, ok_m;
      int unsigned w, h, m, cut, nbytes;
      longint      npx;
      file_q = {};
      if ($urandom_range(99) < 4) begin
         file_q.push_back(($urandom_range(1)) ? CHR_P : 8'($urandom_range(255)));
         file_q.push_back(8'($urandom_range(255)));
      end else begin
         file_q.push_back(CHR_P);
         file_q.push_back(CHR_SIX);
      end
      add_gap(0);
      add_number(1'b1, ok_w, w);
      add_gap(1);
      add_number(1'b1, ok_h, h);
      add_gap(1);
      add_number(1'b0, ok_m, m);
      if ($urandom_range(99) < 70) begin
         file_q.push_back(CHR_LF);
      end else begin
         file_q.push_back(pick_blank() == CHR_LF ? CHR_SP : CHR_CR);
         repeat ($urandom_range(3)) file_q.push_back(($urandom_range(1)) ? "z" : CHR_HASH);
         file_q.push_back(CHR_LF);
      end
      npx = longint'(w) * longint'(h);
      if (ok_w && ok_h && ok_m && npx <= 20) nbytes = 32'(3 * npx);
      else if (ok_w && ok_h && ok_m) nbytes = 3 * $urandom_range(8, 1) + $urandom_range(2);
      else nbytes = $urandom_range(2);
      repeat (nbytes) file_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(99) < 10) repeat ($urandom_range(2, 1))
         file_q.push_back(8'($urandom_range(255)));
      // cut the file short somewhere, possibly before its first byte
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(file_q.size() - 1);
         while (file_q.size() > cut) void'(file_q.pop_back());
      end
      foreach (file_q[i]) send_byte(file_q[i]);
      send_end();
   endtask

   task automatic test_magic();
      send_end();
      send_text("P5");
      send_byte("q");
      send_end();
      send_byte(CHR_P);
      send_end();
   endtask

   task automatic test_tiny_image();
      send_text("P61 1 0\n");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_end();
   endtask

   task automatic test_header_errors();
      send_text("P6 +");
      send_end();
      send_text("P6 1 1 7");
      send_end();
   endtask

   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      hold_ask = ~hold_ask;
      send_text("P6 4 4 255\n");
      repeat (48) send_byte(8'($urandom_range(255)));
      send_end();
      wait_drained();
      tx_idle_on = 1'b1;
   endtask

   task automatic test_random_files();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      while (words_sent < RANDOM_WORDS) send_random_file();
   endtask

   task automatic test_streaming();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      while (words_sent < RANDOM_WORDS + 120) send_random_file();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_noise();
      pps_req_type w;
      repeat (40) begin
         w.data_byte = ($urandom_range(3) == 0) ? CHR_P : 8'($urandom_range(255));
         w.end_of_stream = ($urandom_range(99) < 12);
         send_word(w);
      end
      send_end();
   endtask

   initial begin
      clear_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_magic();
      test_tiny_image();
      test_header_errors();
      test_backpressure();
      test_random_files();
      test_streaming();
      test_noise();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && result_q.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/pps_pkg.sv
design/pps_parser.sv
design/pps_out_buf.sv
design/ppm_p6_stream_parser_core.sv
dv/tb.sv
